>>> src/jrv_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the journal record validator.
// No dependencies; used by every module of the block.
package jrv_pkg;

    // Fixed record header size in bytes
    localparam int HEADER_BYTES = 12;

    // Width of the consumed byte count on the result
    localparam int CONSUMED_W = 17;

    // CRC-16/CCITT-FALSE constants
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_MSB  = 16'h8000;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // One result beat
    typedef struct packed {
        logic                  record_ok;
        logic [CONSUMED_W-1:0] consumed_bytes;
    } result_t;

endpackage

>>> src/jrv_crc_byte.sv
`timescale 1ns / 1ps
// Combinational CRC-16/CCITT-FALSE update for one byte, MSB first.
// Depends on jrv_pkg for the polynomial constants.
module jrv_crc_byte (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);

    // Fold the byte into the top half, then shift out eight bits
    always_comb
    begin
        logic [15:0] crc;
        crc = crc_in ^ {data_in, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if ((crc & jrv_pkg::CRC_MSB) != 16'h0000)
            begin
                crc = {crc[14:0], 1'b0} ^ jrv_pkg::CRC_POLY;
            end
            else
            begin
                crc = {crc[14:0], 1'b0};
            end
        end
        crc_out = crc;
    end

endmodule

>>> src/jrv_parser.sv
`timescale 1ns / 1ps
// Record parser: header field capture, payload CRC and the decision.
// Depends on jrv_pkg and jrv_crc_byte.
module jrv_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output logic              push,
    output jrv_pkg::result_t  result
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_DECIDED
    } phase_t;

    // Header byte positions of the fields that are kept
    localparam logic [3:0] LEN_LO_POS = 4'd0;
    localparam logic [3:0] LEN_HI_POS = 4'd1;
    localparam logic [3:0] CHK_LO_POS = 4'd2;
    localparam logic [3:0] CHK_HI_POS = 4'd3;
    localparam logic [3:0] HDR_LAST   = 4'(jrv_pkg::HEADER_BYTES);

    phase_t      phase_reg,          phase_next;
    logic [3:0]  header_count_reg,   header_count_next;
    logic [15:0] payload_length_reg, payload_length_next;
    logic [15:0] stored_check_reg,   stored_check_next;
    logic [15:0] running_check_reg,  running_check_next;
    logic [15:0] payload_count_reg,  payload_count_next;

    logic [15:0] crc_updated;
    logic [3:0]  header_count_inc;
    logic [15:0] payload_count_inc;
    logic        emit;
    logic        emit_ok;

    jrv_crc_byte u_crc (
        .crc_in  (running_check_reg),
        .data_in (data_byte),
        .crc_out (crc_updated)
    );

    assign header_count_inc  = header_count_reg + 4'd1;
    assign payload_count_inc = payload_count_reg + 16'd1;

    // Next state and decision for the accepted beat
    always_comb
    begin
        phase_next          = phase_reg;
        header_count_next   = header_count_reg;
        payload_length_next = payload_length_reg;
        stored_check_next   = stored_check_reg;
        running_check_next  = running_check_reg;
        payload_count_next  = payload_count_reg;
        emit                = 1'b0;
        emit_ok             = 1'b0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                unique case (header_count_reg)
                    LEN_LO_POS: payload_length_next[7:0]  = data_byte;
                    LEN_HI_POS: payload_length_next[15:8] = data_byte;
                    CHK_LO_POS: stored_check_next[7:0]    = data_byte;
                    CHK_HI_POS: stored_check_next[15:8]   = data_byte;
                    default:    ;
                endcase
                header_count_next = header_count_inc;
                if (header_count_inc >= HDR_LAST)
                begin
                    if (payload_length_next == 16'd0)
                    begin
                        emit       = 1'b1;
                        emit_ok    = (running_check_reg == stored_check_next);
                        phase_next = PH_DECIDED;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                        emit       = last_byte;
                    end
                end
                else
                begin
                    emit = last_byte;
                end
            end
            PH_PAYLOAD:
            begin
                running_check_next = crc_updated;
                payload_count_next = payload_count_inc;
                if (payload_count_inc == payload_length_reg)
                begin
                    emit       = 1'b1;
                    emit_ok    = (crc_updated == stored_check_reg);
                    phase_next = PH_DECIDED;
                end
                else
                begin
                    emit = last_byte;
                end
            end
            default:
            begin
                // Decided: drop bytes until the last mark
            end
        endcase

        // Rearm on the last mark of the buffer
        if (last_byte)
        begin
            phase_next          = PH_HEADER;
            header_count_next   = 4'd0;
            payload_length_next = 16'd0;
            stored_check_next   = 16'd0;
            running_check_next  = jrv_pkg::CRC_INIT;
            payload_count_next  = 16'd0;
        end
    end

    // Result toward the output buffer; the length is complete before the deciding beat
    assign push                  = accept && emit;
    assign result.record_ok      = emit_ok;
    assign result.consumed_bytes = emit_ok
        ? (jrv_pkg::CONSUMED_W'(payload_length_reg)
           + jrv_pkg::CONSUMED_W'(jrv_pkg::HEADER_BYTES))
        : '0;

    // Hold state; advance on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HEADER;
            header_count_reg   <= 4'd0;
            payload_length_reg <= 16'd0;
            stored_check_reg   <= 16'd0;
            running_check_reg  <= jrv_pkg::CRC_INIT;
            payload_count_reg  <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg          <= phase_next;
            header_count_reg   <= header_count_next;
            payload_length_reg <= payload_length_next;
            stored_check_reg   <= stored_check_next;
            running_check_reg  <= running_check_next;
            payload_count_reg  <= payload_count_next;
        end
    end

endmodule

>>> src/jrv_out_buf.sv
`timescale 1ns / 1ps
// Result register with a skid stage toward the output channel.
// Depends on jrv_pkg for the result type.
module jrv_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  jrv_pkg::result_t  push_data,
    output logic              space,
    output logic              out_valid,
    input  logic              out_ready,
    output jrv_pkg::result_t  out_data
);

    logic             head_valid_reg;
    logic             skid_valid_reg;
    jrv_pkg::result_t head_data_reg;
    jrv_pkg::result_t skid_data_reg;
    logic             head_free;

    // Head slot frees when empty or taken this cycle
    assign head_free = !head_valid_reg || out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_data_reg;

    // Control: head and skid occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (head_free)
        begin
            head_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload: move skid forward or catch the new beat
    always_ff @(posedge clk)
    begin
        if (head_free)
        begin
            head_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

endmodule

>>> src/journal_record_validator.sv
`timescale 1ns / 1ps
// Top level of the journal record validator.
// Depends on jrv_pkg, jrv_parser and jrv_out_buf.

// Takes one buffer byte per cycle, parses the 12-byte little-endian record
// header (payload length in bytes 0..1, stored CRC in bytes 2..3), runs a
// CRC-16/CCITT-FALSE over the payload and gives one result per record: ok
// with header plus payload length, or not ok with 0 for a mismatch or a
// record cut short by last_byte. Bytes after the decision are dropped up to
// the next last_byte, which rearms the parser. Throughput, while in_ready is
// high, is one byte per cycle; the byte CRC update is a single
// combinational stage. A result goes to the output register, or to the skid
// stage while that is held; in_ready drops only when both hold a result.
module journal_record_validator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      data_byte,
    input  logic                            last_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            record_ok,
    output logic [jrv_pkg::CONSUMED_W-1:0]  consumed_bytes
);

    logic             accept;
    logic             push;
    logic             space;
    jrv_pkg::result_t push_data;
    jrv_pkg::result_t out_data;

    assign in_ready = space;
    assign accept   = in_valid && space;

    jrv_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .push      (push),
        .result    (push_data)
    );

    jrv_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign record_ok      = out_data.record_ok;
    assign consumed_bytes = out_data.consumed_bytes;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for journal_record_validator: byte stream in, one verdict out.
// Depends on jrv_pkg and the journal_record_validator RTL.
module testbench;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_BYTES  = 1500;
    localparam int REPORT_MAX    = 10;
    localparam int IDLE_PERCENT  = 14;
    localparam int DRAIN_CYCLES  = 8;

    // Byte offsets of the fields kept from the header
    localparam int LEN_LO_POS = 0;
    localparam int LEN_HI_POS = 1;
    localparam int CRC_LO_POS = 2;
    localparam int CRC_HI_POS = 3;

    typedef enum logic [1:0] {PH_HEADER, PH_PAYLOAD, PH_DECIDED} parse_phase_t;

    logic                           clk;
    logic                           rst_n          = 1'b0;
    logic                           in_valid       = 1'b0;
    logic                           in_ready;
    logic [7:0]                     data_byte      = 8'h00;
    logic                           last_byte      = 1'b0;
    logic                           out_valid;
    logic                           out_ready      = 1'b0;
    logic                           record_ok;
    logic [jrv_pkg::CONSUMED_W-1:0] consumed_bytes;

    // Tracked record state
    parse_phase_t parse_phase;
    int unsigned  header_seen;
    logic [15:0]  rec_length;
    logic [15:0]  rec_stored_crc;
    logic [15:0]  rec_running_crc;
    logic [15:0]  payload_seen;

    jrv_pkg::result_t pending_verdicts[$];
    logic [7:0]       frame_bytes[$];
    int unsigned      mismatch_count = 0;
    int unsigned      bytes_sent     = 0;
    int unsigned      cycle_count    = 0;
    bit               steady_run     = 1'b0;

    journal_record_validator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .record_ok      (record_ok),
        .consumed_bytes (consumed_bytes)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("journal_record_validator regression: fail");
            $finish;
        end
    end

    // CRC-16/CCITT-FALSE update for one byte, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
            c = (c & jrv_pkg::CRC_MSB) != 0 ? ((c << 1) ^ jrv_pkg::CRC_POLY) : (c << 1);
        return c;
    endfunction

    task automatic rearm_tracker();
        parse_phase     = PH_HEADER;
        header_seen     = 0;
        rec_length      = '0;
        rec_stored_crc  = '0;
        rec_running_crc = jrv_pkg::CRC_INIT;
        payload_seen    = '0;
    endtask

    // Advance the tracked record by one accepted byte; queue any verdict it decides
    task automatic track_record_byte(input logic [7:0] b, input logic last);
        bit               decided;
        bit               ok;
        jrv_pkg::result_t verdict;
        decided = 1'b0;
        ok      = 1'b0;
        unique case (parse_phase)
            PH_HEADER:
            begin
                unique case (header_seen)
                    LEN_LO_POS: rec_length[7:0]      = b;
                    LEN_HI_POS: rec_length[15:8]     = b;
                    CRC_LO_POS: rec_stored_crc[7:0]  = b;
                    CRC_HI_POS: rec_stored_crc[15:8] = b;
                    default: ;
                endcase
                header_seen++;
                if (header_seen == jrv_pkg::HEADER_BYTES)
                begin
                    if (rec_length == 0)
                    begin
                        decided     = 1'b1;
                        ok          = (rec_running_crc == rec_stored_crc);
                        parse_phase = PH_DECIDED;
                    end
                    else
                    begin
                        parse_phase = PH_PAYLOAD;
                        decided     = last;
                    end
                end
                else
                begin
                    decided = last;
                end
            end
            PH_PAYLOAD:
            begin
                rec_running_crc = crc16_byte(rec_running_crc, b);
                payload_seen    = payload_seen + 1'b1;
                if (payload_seen == rec_length)
                begin
                    decided     = 1'b1;
                    ok          = (rec_running_crc == rec_stored_crc);
                    parse_phase = PH_DECIDED;
                end
                else
                begin
                    decided = last;
                end
            end
            default: ;
        endcase
        if (decided)
        begin
            verdict.record_ok      = ok;
            verdict.consumed_bytes = ok
                ? jrv_pkg::CONSUMED_W'(jrv_pkg::HEADER_BYTES + int'(rec_length)) : '0;
            pending_verdicts.push_back(verdict);
        end
        if (last)
            rearm_tracker();
    endtask

    // Send one byte beat; returns at the edge that accepts it
    task automatic send_byte(input logic [7:0] b, input logic last);
        bit taken;
        while (!steady_run && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end while (!taken);
        bytes_sent++;
        track_record_byte(b, last);
    endtask

    // Fill frame_bytes with a header and payload; optionally corrupt the stored CRC
    task automatic build_record(input logic [15:0] len, input bit bad_crc);
        logic [15:0] crc;
        logic [7:0]  payload[$];
        crc = jrv_pkg::CRC_INIT;
        for (int i = 0; i < int'(len); i++)
        begin
            payload.push_back(8'($urandom));
            crc = crc16_byte(crc, payload[i]);
        end
        if (bad_crc)
            crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
        frame_bytes = {len[7:0], len[15:8], crc[7:0], crc[15:8]};
        for (int i = 4; i < jrv_pkg::HEADER_BYTES; i++)
            frame_bytes.push_back(8'($urandom));
        frame_bytes = {frame_bytes, payload};
    endtask

    task automatic add_trailing_bytes(input int count);
        repeat (count) frame_bytes.push_back(8'($urandom));
    endtask

    // Send frame_bytes as one buffer, marking the final byte
    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    task automatic send_cut_record(input logic [15:0] len, input int keep);
        build_record(len, 1'b0);
        while (frame_bytes.size() > keep)
            void'(frame_bytes.pop_back());
        send_frame();
    endtask

    task automatic send_noise(input int count);
        for (int i = 0; i < count; i++)
            send_byte(8'($urandom), i == count - 1 || $urandom_range(15) == 0);
    endtask

    task automatic note_mismatch(input string what, input jrv_pkg::result_t exp_r,
                                 input jrv_pkg::result_t act_r);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%0t %s: expected ok=%0b consumed=%0d, got ok=%0b consumed=%0d", $realtime,
                     what, exp_r.record_ok, exp_r.consumed_bytes,
                     act_r.record_ok, act_r.consumed_bytes);
    endtask

    // Compare each verdict beat against the oldest queued expectation; drive out_ready
    initial
    begin
        bit               got;
        jrv_pkg::result_t seen;
        jrv_pkg::result_t want;
        forever
        begin
            @(negedge clk);
            got                 = out_valid && out_ready;
            seen.record_ok      = record_ok;
            seen.consumed_bytes = consumed_bytes;
            @(posedge clk);
            if (got)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    want = '0;
                    note_mismatch("unexpected verdict", want, seen);
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (want.record_ok !== seen.record_ok ||
                        want.consumed_bytes !== seen.consumed_bytes)
                        note_mismatch("verdict mismatch", want, seen);
                end
            end
            out_ready <= steady_run || $urandom_range(99) >= IDLE_PERCENT;
        end
    end

    // Zero-length payload: decided on the last header byte against the initial CRC
    task automatic test_empty_payload();
        build_record(16'd0, 1'b0);
        send_frame();
        build_record(16'd0, 1'b1);
        send_frame();
        build_record(16'd0, 1'b0);
        add_trailing_bytes(3);
        send_frame();
    endtask

    // Last mark before the header or the payload is complete
    task automatic test_cut_short();
        send_cut_record(16'd4, 1);
        send_cut_record(16'd4, jrv_pkg::HEADER_BYTES - 1);
        send_cut_record(16'd4, jrv_pkg::HEADER_BYTES);
        send_cut_record(16'd6, jrv_pkg::HEADER_BYTES + 3);
        send_cut_record(16'hFFFF, jrv_pkg::HEADER_BYTES + 1);
    endtask

    // Stored CRC differs from the computed one
    task automatic test_crc_mismatch();
        build_record(16'd5, 1'b1);
        send_frame();
        build_record(16'd2, 1'b1);
        add_trailing_bytes(2);
        send_frame();
    endtask

    // Extreme byte values, and a length whose low byte is zero
    task automatic test_field_extremes();
        frame_bytes = {8'h01, 8'h00};
        build_record(16'd1, 1'b0);
        frame_bytes[jrv_pkg::HEADER_BYTES] = 8'hFF;
        frame_bytes[CRC_LO_POS] = 8'(crc16_byte(jrv_pkg::CRC_INIT, 8'hFF));
        frame_bytes[CRC_HI_POS] = 8'(crc16_byte(jrv_pkg::CRC_INIT, 8'hFF) >> 8);
        send_frame();
        build_record(16'd1, 1'b0);
        frame_bytes[jrv_pkg::HEADER_BYTES] = 8'h00;
        frame_bytes[CRC_LO_POS] = 8'(crc16_byte(jrv_pkg::CRC_INIT, 8'h00));
        frame_bytes[CRC_HI_POS] = 8'(crc16_byte(jrv_pkg::CRC_INIT, 8'h00) >> 8);
        add_trailing_bytes(1);
        send_frame();
        build_record(16'h0100, 1'b0);
        send_frame();
    endtask

    // Trailing bytes after a decision, with last marks scattered in the stream
    task automatic test_noise();
        send_noise(40);
    endtask

    // Mostly well-formed records with random content, mixed with broken ones and noise
    task automatic test_random_records();
        int unsigned start_count;
        int unsigned done;
        int unsigned pick;
        logic [15:0] len;
        start_count = bytes_sent;
        done        = 0;
        while (done < RANDOM_BYTES)
        begin
            steady_run = (done > RANDOM_BYTES / 3) && (done < RANDOM_BYTES / 2);
            pick = $urandom_range(99);
            len  = ($urandom_range(19) == 0) ? 16'($urandom_range(25, 300))
                                             : 16'($urandom_range(1, 24));
            if (pick < 58)
            begin
                build_record(len, 1'b0);
                add_trailing_bytes($urandom_range(0, 3));
                send_frame();
            end
            else if (pick < 70)
            begin
                build_record(len, 1'b1);
                add_trailing_bytes($urandom_range(0, 2));
                send_frame();
            end
            else if (pick < 82)
            begin
                len = ($urandom_range(1) == 0) ? 16'($urandom) : len;
                send_cut_record(len, $urandom_range(1,
                                jrv_pkg::HEADER_BYTES + int'(len) - 1 > 40 ?
                                40 : jrv_pkg::HEADER_BYTES + int'(len) - 1));
            end
            else if (pick < 92)
            begin
                build_record(16'd0, $urandom_range(3) == 0);
                add_trailing_bytes($urandom_range(0, 2));
                send_frame();
            end
            else
            begin
                send_noise($urandom_range(1, 30));
            end
            done = bytes_sent - start_count;
        end
        steady_run = 1'b0;
    endtask

    initial
    begin
        rearm_tracker();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_payload();
        test_cut_short();
        test_crc_mismatch();
        test_field_extremes();
        test_noise();
        test_random_records();

        // Drain outstanding verdicts
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("journal_record_validator regression: pass");
        else
            $display("journal_record_validator regression: fail");
        $finish;
    end

endmodule
